// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the deframer.
// Include this header by its bare name; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/core/tfd_pkg.sv =====
// Package of the telemetry deframer: types, packet layout constants and the CRC-32 byte update.
// Used by every module of the block; depends on nothing.
package tfd_pkg;

  localparam int unsigned PosWidth = 20;
  localparam int unsigned OutDataWidth = 88;

  localparam logic [PosWidth-1:0] HdrBytes = 20'd24;
  localparam logic [PosWidth-1:0] CrcBytesMinus1 = 20'd3;
  localparam logic [PosWidth-1:0] SeqEndPos = 20'd15;
  localparam logic [PosWidth-1:0] TsEndPos = 20'd23;
  localparam logic [15:0] MaxChannels = 16'hFFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;

  localparam logic [7:0] Magic [4] = '{8'h47, 8'h4C, 8'h48, 8'h57};

  // Result kinds, carried on tuser.
  localparam logic [1:0] KindSequence = 2'd0;
  localparam logic [1:0] KindTimestamp = 2'd1;
  localparam logic [1:0] KindValue = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  // Configuration register indexes.
  localparam logic RegChannelCount = 1'b0;
  localparam logic RegVersion = 1'b1;

  // Bits of the error flag vector; status code is the first set bit plus one.
  localparam int unsigned ErrSize = 0;
  localparam int unsigned ErrMagic = 1;
  localparam int unsigned ErrVersion = 2;
  localparam int unsigned ErrCount = 3;
  localparam int unsigned ErrCrc = 4;
  localparam int unsigned ErrTimestamp = 5;
  localparam int unsigned ErrValue = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } tfd_item_t;

  typedef struct packed {
    logic [15:0] channel_count;
    logic [7:0]  version_expected;
  } tfd_cfg_t;

  // One byte through the reflected CRC-32, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/tfd_in_stage.sv =====
// Input register of the deframer: holds one accepted byte until the parser takes it.
// Depends on tfd_pkg for the item type.
module tfd_in_stage import tfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  tfd_item_t item_i,
  input  logic      advance_i,
  output logic      valid_o,
  output tfd_item_t item_o
);

  logic      valid_q, valid_d;
  tfd_item_t item_q;
  logic      load;

  // The slot frees in the same cycle that the parser consumes it.
  assign s_axis_tready = !valid_q || advance_i;
  assign load = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

// ===== rtl/core/tfd_parser.sv =====
// Packet parser of the deframer: packet state, header and word checks, CRC and result register.
// Depends on tfd_pkg for constants, types and the CRC byte update.
module tfd_parser import tfd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  tfd_item_t               item_i,
  input  tfd_cfg_t                cfg_i,
  output logic                    advance_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [1:0]              res_kind_o,
  output logic [63:0]             res_word_o,
  output logic [15:0]             res_index_o,
  output logic [2:0]              res_status_o,
  output logic                    res_last_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         crc_q, crc_d;
  logic [63:0]         asm_q, asm_d;
  logic [31:0]         trl_q, trl_d;
  logic [6:0]          err_q, err_d;
  logic [7:0]          cnt_lo_q, cnt_lo_d;

  logic                res_valid_q, res_valid_d;
  logic [1:0]          kind_q, kind_d;
  logic [63:0]         word_q, word_d;
  logic [15:0]         index_q, index_d;
  logic [2:0]          status_q, status_d;
  logic                last_q, last_d;

  logic [PosWidth-1:0] body_end;
  logic [PosWidth-1:0] pos_rel;
  logic [6:0]          flags;
  logic                word_hit;
  logic                inf_nan;
  logic                has_res;
  logic [7:0]          b;

  assign advance_o = item_valid_i && (!res_valid_q || res_ready_i);
  assign b = item_i.data_byte;
  // First byte of the CRC trailer.
  assign body_end = HdrBytes + {1'b0, cfg_i.channel_count, 3'b000};
  assign pos_rel = pos_q - HdrBytes;

  always_comb begin
    err_d = err_q;
    cnt_lo_d = cnt_lo_q;
    if (pos_q < 20'd4) begin
      if (b != Magic[pos_q[1:0]]) err_d[ErrMagic] = 1'b1;
    end else if (pos_q == 20'd4) begin
      if (b != cfg_i.version_expected) err_d[ErrVersion] = 1'b1;
    end else if (pos_q == 20'd5) begin
      if (b != 8'd0) err_d[ErrVersion] = 1'b1;
    end else if (pos_q == 20'd6) begin
      cnt_lo_d = b;
    end else if (pos_q == 20'd7) begin
      if ({b, cnt_lo_q} != cfg_i.channel_count) err_d[ErrCount] = 1'b1;
    end

    crc_d = (pos_q < body_end) ? crc_byte(crc_q, b) : crc_q;
    asm_d = {b, asm_q[63:8]};
    trl_d = {b, trl_q[31:8]};

    word_hit = (pos_q >= SeqEndPos) && (pos_q[2:0] == 3'd7) && (pos_q < body_end);
    inf_nan = (asm_d[62:52] == 11'h7FF);
    kind_d = KindValue;
    index_d = 16'd0;
    if (pos_q == SeqEndPos) begin
      kind_d = KindSequence;
    end else if (pos_q == TsEndPos) begin
      kind_d = KindTimestamp;
      if (word_hit && (inf_nan || (asm_d[63] && asm_d != NegZero))) begin
        err_d[ErrTimestamp] = 1'b1;
      end
    end else begin
      index_d = pos_rel[18:3];
      if (word_hit && inf_nan) err_d[ErrValue] = 1'b1;
    end
    word_d = asm_d;
    status_d = 3'd0;
    last_d = 1'b0;
    has_res = word_hit;

    // Closing status: size and CRC are settled only on the end byte.
    flags = err_d;
    if (pos_q != body_end + CrcBytesMinus1) flags[ErrSize] = 1'b1;
    if (~crc_d != trl_d) flags[ErrCrc] = 1'b1;
    if (item_i.end_of_packet) begin
      has_res = 1'b1;
      kind_d = KindStatus;
      word_d = 64'd0;
      index_d = 16'd0;
      last_d = 1'b1;
      for (int k = 6; k >= 0; k--) begin
        if (flags[k]) status_d = 3'(k + 1);
      end
    end

    pos_d = (pos_q != '1) ? pos_q + 20'd1 : pos_q;
    if (item_i.end_of_packet) begin
      pos_d = '0;
      crc_d = CrcInit;
      asm_d = '0;
      trl_d = '0;
      err_d = '0;
      cnt_lo_d = '0;
    end

    res_valid_d = res_valid_q;
    if (advance_o) begin
      res_valid_d = has_res;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
      asm_q <= '0;
      trl_q <= '0;
      err_q <= '0;
      cnt_lo_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (advance_o) begin
        pos_q <= pos_d;
        crc_q <= crc_d;
        asm_q <= asm_d;
        trl_q <= trl_d;
        err_q <= err_d;
        cnt_lo_q <= cnt_lo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && has_res) begin
      kind_q <= kind_d;
      word_q <= word_d;
      index_q <= index_d;
      status_q <= status_d;
      last_q <= last_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_kind_o = kind_q;
  assign res_word_o = word_q;
  assign res_index_o = index_q;
  assign res_status_o = status_q;
  assign res_last_o = last_q;

endmodule

// ===== rtl/core/telemetry_frame_deframer_crc32.sv =====
// Telemetry deframer with CRC-32 check: top level with configuration registers and stream ports.
// Throughput: one byte per cycle while the master side takes results, set by the single parser
// stage between the input register and the result register; the byte CRC update is one unrolled
// block of logic in that stage.
// Reset: rst_ni is asynchronous and active low; it empties both registers, returns the
// packet state to the start of a packet and sets channel_count to 0 and version_expected to 1.
// Depends on tfd_pkg, tfd_in_stage and tfd_parser.
module telemetry_frame_deframer_crc32 import tfd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  // Byte stream in.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
  input  logic                    s_axis_tlast,   // end_of_packet
  // Result stream out.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,   // [63:0] word, [79:64] value_index,
                                                  // [82:80] status, [87:83] zero
  output logic [1:0]              m_axis_tuser,   // [1:0] kind
  output logic                    m_axis_tlast    // last
);

  tfd_cfg_t  cfg_q;
  tfd_item_t in_item;
  tfd_item_t stage_item;
  logic      stage_valid;
  logic      advance;
  logic [63:0] res_word;
  logic [15:0] res_index;
  logic [2:0]  res_status;

  // Register writes. A channel count is held no larger than the supported maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= 16'd0;
      cfg_q.version_expected <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegChannelCount: begin
          cfg_q.channel_count <= (cfg_data_i > MaxChannels) ? MaxChannels : cfg_data_i;
        end
        RegVersion: begin
          cfg_q.version_expected <= cfg_data_i[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.end_of_packet = s_axis_tlast;

  // The input register lets a byte be taken while the previous result still waits.
  tfd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .item_i        (in_item),
    .advance_i     (advance),
    .valid_o       (stage_valid),
    .item_o        (stage_item)
  );

  // The parser updates the packet state and loads the result register in one step.
  tfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .cfg_i        (cfg_q),
    .advance_o    (advance),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_word_o   (res_word),
    .res_index_o  (res_index),
    .res_status_o (res_status),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res_status, res_index, res_word};

endmodule

// ===== rtl/core/tfd_checker.sv =====
// Port-level checker for the telemetry deframer, bound to the top level.
// Depends on tfd_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module tfd_checker import tfd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [OutDataWidth-1:0] m_axis_tdata,
  input logic [1:0]              m_axis_tuser,
  input logic                    m_axis_tlast
);

  `TFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `TFD_ASSERT_NOW(a_last_is_status, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == KindStatus))
  `TFD_ASSERT_NOW(a_word_no_status, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[82:80] == 3'd0)
  `TFD_ASSERT_NOW(a_status_no_word, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[79:0] == 80'd0)

endmodule

bind telemetry_frame_deframer_crc32 tfd_checker u_tfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
